@@ rtl/segment_intersection_2d_macros.svh @@
// ---------------------------------------------------------------------------
// segment intersection assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_2D_MACROS_SVH
`define SEGMENT_INTERSECTION_2D_MACROS_SVH

// same-cycle implication, held off during reset
`define SEGIX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define SEGIX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/segix_pkg.sv @@
// ---------------------------------------------------------------------------
// segix_pkg
// word types and widths of the segment intersection block
// ---------------------------------------------------------------------------
package segix_pkg;

  localparam int COORD_W        = 16;
  localparam int POINT_W        = 24;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_start_x;
    logic signed [COORD_W-1:0] first_start_y;
    logic signed [COORD_W-1:0] first_end_x;
    logic signed [COORD_W-1:0] first_end_y;
    logic signed [COORD_W-1:0] second_start_x;
    logic signed [COORD_W-1:0] second_start_y;
    logic signed [COORD_W-1:0] second_end_x;
    logic signed [COORD_W-1:0] second_end_y;
  } seg_pair_t;

  typedef struct packed {
    logic                      hit;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic                      collinear;
  } isect_t;

  // flags and base point that ride along the divider
  typedef struct packed {
    logic                      hit;
    logic                      collinear;
    logic                      use_q;
    logic signed [POINT_W-1:0] base_x;
    logic signed [POINT_W-1:0] base_y;
  } side_t;

endpackage

@@ rtl/segment_intersection_2d.sv @@
// ---------------------------------------------------------------------------
// segment_intersection_2d
// streaming 2d segment-pair intersector with a fixed-point crossing point
// ---------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_word carry one segment pair (a->b, c->d) per word;
//   out_valid/out_stall/out_word return one result word per input word, in
//   order: hit flag, crossing point with FRAC_BITS fraction bits, and a flag
//   telling whether the hit came from the collinear overlap path
//   a word is taken at a clock edge with valid high and stall low
// pipeline: four geometry stages, a bit-per-stage divider of COORD_BITS +
//   FRAC_BITS + 3 stages (an entry stage and one per quotient bit) and the
//   output register
// throughput: one word per cycle while the pipe is not stalled; the depth is
//   set by the restoring divider
// reset: synchronous active-low rst_n clears every valid bit, so the pipe
//   comes out empty; payload registers are not reset
// stall: while a result sits in the output register with out_stall high the
//   whole pipe holds and in_stall is raised; nothing is dropped or repeated
// ---------------------------------------------------------------------------
module segment_intersection_2d import segix_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  seg_pair_t in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output isect_t    out_word
);

  localparam int CB  = COORD_BITS;
  localparam int DF  = CB + 1;          // coordinate differences
  localparam int PRD = 2 * DF + 1;      // cross and dot products
  localparam int SW  = DF + PRD;        // direction times numerator
  localparam int NW  = SW + FRAC_BITS + 1;
  localparam int QW  = DF + FRAC_BITS + 1;
  localparam int DVW = PRD + 1;

  // take the low COORD_BITS of a field as a signed coordinate
  function automatic logic signed [CB-1:0] coord(input logic [COORD_W-1:0] f);
    coord = CB'(f);
  endfunction

  function automatic logic signed [2*DF-1:0] mul_d(input logic signed [DF-1:0] a,
                                                   input logic signed [DF-1:0] b);
    mul_d = a * b;
  endfunction

  function automatic logic signed [SW-1:0] mul_s(input logic signed [DF-1:0] a,
                                                 input logic signed [PRD-1:0] b);
    mul_s = a * b;
  endfunction

  // global advance: the pipe moves unless a finished word is held up
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // -------------------------------------------------------------------------
  // stage 1: coordinates and differences
  // -------------------------------------------------------------------------
  logic                 v1_r;
  logic signed [CB-1:0] ax_r1, ay_r1, bx_r1, by_r1, cx_r1, cy_r1, dx_r1, dy_r1;
  logic signed [DF-1:0] d1x_r1, d1y_r1, d2x_r1, d2y_r1, ex_r1, ey_r1;
  logic signed [DF-1:0] fx_r1, fy_r1, gx_r1, gy_r1;
  logic signed [CB-1:0] ax_nxt, ay_nxt, bx_nxt, by_nxt, cx_nxt, cy_nxt, dx_nxt, dy_nxt;

  always_comb begin
    ax_nxt = coord(in_word.first_start_x);
    ay_nxt = coord(in_word.first_start_y);
    bx_nxt = coord(in_word.first_end_x);
    by_nxt = coord(in_word.first_end_y);
    cx_nxt = coord(in_word.second_start_x);
    cy_nxt = coord(in_word.second_start_y);
    dx_nxt = coord(in_word.second_end_x);
    dy_nxt = coord(in_word.second_end_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r1  <= ax_nxt;  ay_r1 <= ay_nxt;
      bx_r1  <= bx_nxt;  by_r1 <= by_nxt;
      cx_r1  <= cx_nxt;  cy_r1 <= cy_nxt;
      dx_r1  <= dx_nxt;  dy_r1 <= dy_nxt;
      d1x_r1 <= DF'(bx_nxt) - DF'(ax_nxt);
      d1y_r1 <= DF'(by_nxt) - DF'(ay_nxt);
      d2x_r1 <= DF'(dx_nxt) - DF'(cx_nxt);
      d2y_r1 <= DF'(dy_nxt) - DF'(cy_nxt);
      ex_r1  <= DF'(cx_nxt) - DF'(ax_nxt);   // c - a
      ey_r1  <= DF'(cy_nxt) - DF'(ay_nxt);
      fx_r1  <= DF'(dx_nxt) - DF'(ax_nxt);   // d - a
      fy_r1  <= DF'(dy_nxt) - DF'(ay_nxt);
      gx_r1  <= DF'(bx_nxt) - DF'(cx_nxt);   // b - c
      gy_r1  <= DF'(by_nxt) - DF'(cy_nxt);
    end
  end

  // -------------------------------------------------------------------------
  // stage 2: cross products, projections and squared lengths
  // -------------------------------------------------------------------------
  logic                  v2_r;
  logic                  zero_r2;
  logic signed [PRD-1:0] den_r2, tn_r2, un_r2;
  logic signed [PRD-1:0] pd_r2, pc_r2, pb_r2, pa_r2, l1_r2, l2_r2;
  logic signed [CB-1:0]  ax_r2, ay_r2, bx_r2, by_r2, cx_r2, cy_r2, dx_r2, dy_r2;
  logic signed [DF-1:0]  d1x_r2, d1y_r2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // a zero-length segment never hits
      zero_r2 <= (d1x_r1 == '0 && d1y_r1 == '0) || (d2x_r1 == '0 && d2y_r1 == '0);
      den_r2  <= PRD'(mul_d(d1x_r1, d2y_r1)) - PRD'(mul_d(d1y_r1, d2x_r1));
      tn_r2   <= PRD'(mul_d(ex_r1, d2y_r1)) - PRD'(mul_d(ey_r1, d2x_r1));
      un_r2   <= PRD'(mul_d(ex_r1, d1y_r1)) - PRD'(mul_d(ey_r1, d1x_r1));
      pd_r2   <= PRD'(mul_d(d1x_r1, fx_r1)) + PRD'(mul_d(d1y_r1, fy_r1));
      pc_r2   <= PRD'(mul_d(d1x_r1, ex_r1)) + PRD'(mul_d(d1y_r1, ey_r1));
      pb_r2   <= PRD'(mul_d(d2x_r1, gx_r1)) + PRD'(mul_d(d2y_r1, gy_r1));
      pa_r2   <= -(PRD'(mul_d(d2x_r1, ex_r1)) + PRD'(mul_d(d2y_r1, ey_r1)));
      l1_r2   <= PRD'(mul_d(d1x_r1, d1x_r1)) + PRD'(mul_d(d1y_r1, d1y_r1));
      l2_r2   <= PRD'(mul_d(d2x_r1, d2x_r1)) + PRD'(mul_d(d2y_r1, d2y_r1));
      ax_r2   <= ax_r1;  ay_r2 <= ay_r1;
      bx_r2   <= bx_r1;  by_r2 <= by_r1;
      cx_r2   <= cx_r1;  cy_r2 <= cy_r1;
      dx_r2   <= dx_r1;  dy_r2 <= dy_r1;
      d1x_r2  <= d1x_r1; d1y_r2 <= d1y_r1;
    end
  end

  // -------------------------------------------------------------------------
  // stage 3: sign fold, range checks and collinear endpoint pick
  // -------------------------------------------------------------------------
  logic                  dneg;
  logic signed [PRD-1:0] dena, tna, una;
  logic                  cross_ok, col_ok;
  logic                  in_d, in_c, in_b, in_a;
  logic signed [CB-1:0]  sx_nxt, sy_nxt;

  always_comb begin
    dneg     = den_r2[PRD-1];
    dena     = dneg ? -den_r2 : den_r2;
    tna      = dneg ? -tn_r2 : tn_r2;
    una      = dneg ? -un_r2 : un_r2;
    cross_ok = !zero_r2 && den_r2 != '0 &&
               !tna[PRD-1] && tna <= dena && !una[PRD-1] && una <= dena;
    // strictly inside: 0 < projection < squared length
    in_d     = pd_r2 > 0 && pd_r2 < l1_r2;
    in_c     = pc_r2 > 0 && pc_r2 < l1_r2;
    in_b     = pb_r2 > 0 && pb_r2 < l2_r2;
    in_a     = pa_r2 > 0 && pa_r2 < l2_r2;
    col_ok   = !zero_r2 && den_r2 == '0 && un_r2 == '0 && (in_d || in_c || in_b || in_a);
    if (in_d) begin
      sx_nxt = dx_r2; sy_nxt = dy_r2;
    end else if (in_c) begin
      sx_nxt = cx_r2; sy_nxt = cy_r2;
    end else if (in_b) begin
      sx_nxt = bx_r2; sy_nxt = by_r2;
    end else begin
      sx_nxt = ax_r2; sy_nxt = ay_r2;
    end
  end

  logic                  v3_r;
  logic                  hitc_r3, hitl_r3;
  logic signed [CB-1:0]  sx_r3, sy_r3, ax_r3, ay_r3;
  logic signed [DF-1:0]  d1x_r3, d1y_r3;
  logic signed [PRD-1:0] tn_r3, den_r3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hitc_r3 <= cross_ok;
      hitl_r3 <= col_ok;
      sx_r3   <= sx_nxt;  sy_r3 <= sy_nxt;
      ax_r3   <= ax_r2;   ay_r3 <= ay_r2;
      d1x_r3  <= d1x_r2;  d1y_r3 <= d1y_r2;
      tn_r3   <= tna;
      den_r3  <= dena;
    end
  end

  // -------------------------------------------------------------------------
  // stage 4: direction times t numerator
  // -------------------------------------------------------------------------
  logic                  v4_r;
  logic                  hitc_r4, hitl_r4;
  logic signed [CB-1:0]  sx_r4, sy_r4, ax_r4, ay_r4;
  logic signed [SW-1:0]  mx_r4, my_r4;
  logic signed [PRD-1:0] den_r4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hitc_r4 <= hitc_r3;
      hitl_r4 <= hitl_r3;
      sx_r4   <= sx_r3;  sy_r4 <= sy_r3;
      ax_r4   <= ax_r3;  ay_r4 <= ay_r3;
      mx_r4   <= mul_s(d1x_r3, tn_r3);
      my_r4   <= mul_s(d1y_r3, tn_r3);
      den_r4  <= den_r3;
    end
  end

  // -------------------------------------------------------------------------
  // divider feed: round to nearest as floor((2*m*2^F + den) / (2*den))
  // -------------------------------------------------------------------------
  logic signed [NW-1:0] nx, ny;
  logic [NW-1:0]        mag_x, mag_y;
  logic [DVW-1:0]       divisor;
  side_t                side_nxt;

  always_comb begin
    nx      = (NW'(mx_r4) <<< (FRAC_BITS + 1)) + NW'(den_r4);
    ny      = (NW'(my_r4) <<< (FRAC_BITS + 1)) + NW'(den_r4);
    mag_x   = nx[NW-1] ? ~nx : nx;
    mag_y   = ny[NW-1] ? ~ny : ny;
    divisor = {den_r4, 1'b0};
    side_nxt.hit       = hitc_r4 || hitl_r4;
    side_nxt.collinear = hitl_r4;
    side_nxt.use_q     = hitc_r4;
    if (hitc_r4) begin
      side_nxt.base_x = POINT_W'(ax_r4) << FRAC_BITS;
      side_nxt.base_y = POINT_W'(ay_r4) << FRAC_BITS;
    end else if (hitl_r4) begin
      side_nxt.base_x = POINT_W'(sx_r4) << FRAC_BITS;
      side_nxt.base_y = POINT_W'(sy_r4) << FRAC_BITS;
    end else begin
      side_nxt.base_x = '0;
      side_nxt.base_y = '0;
    end
  end

  logic                div_valid;
  logic signed [QW:0]  qx, qy;
  side_t               div_side;

  segix_div #(
    .NW  (NW),
    .DVW (DVW),
    .QW  (QW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v4_r),
    .in_num_x  (mag_x),
    .in_num_y  (mag_y),
    .in_neg_x  (nx[NW-1]),
    .in_neg_y  (ny[NW-1]),
    .in_div    (divisor),
    .in_side   (side_nxt),
    .out_valid (div_valid),
    .out_q_x   (qx),
    .out_q_y   (qy),
    .out_side  (div_side)
  );

  // -------------------------------------------------------------------------
  // output register: base point plus rounded offset
  // -------------------------------------------------------------------------
  logic   out_valid_r;
  isect_t out_word_r, out_word_nxt;

  always_comb begin
    out_word_nxt.hit       = div_side.hit;
    out_word_nxt.collinear = div_side.collinear;
    out_word_nxt.point_x   = div_side.base_x + (div_side.use_q ? POINT_W'(qx) : '0);
    out_word_nxt.point_y   = div_side.base_y + (div_side.use_q ? POINT_W'(qy) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ rtl/segix_div.sv @@
// ---------------------------------------------------------------------------
// segix_div
// pipelined restoring divider, two dividends over one divisor, one bit a stage
// ---------------------------------------------------------------------------
module segix_div import segix_pkg::*; #(
  parameter int NW  = 61,
  parameter int DVW = 36,
  parameter int QW  = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [NW-1:0]       in_num_x,
  input  logic [NW-1:0]       in_num_y,
  input  logic                in_neg_x,
  input  logic                in_neg_y,
  input  logic [DVW-1:0]      in_div,
  input  side_t               in_side,
  output logic                out_valid,
  output logic signed [QW:0]  out_q_x,
  output logic signed [QW:0]  out_q_y,
  output side_t               out_side
);

  logic             v_r    [0:QW];
  logic [DVW-1:0]   div_r  [0:QW];
  side_t            side_r [0:QW];
  logic [DVW-1:0]   rem_r  [0:QW][0:1];
  logic [QW-1:0]    low_r  [0:QW][0:1];
  logic [QW-1:0]    q_r    [0:QW][0:1];
  logic             neg_r  [0:QW][0:1];

  // entry stage: split dividend into starting remainder and bits to bring down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0]    <= in_div;
      side_r[0]   <= in_side;
      rem_r[0][0] <= DVW'(in_num_x[NW-1:QW]);
      rem_r[0][1] <= DVW'(in_num_y[NW-1:QW]);
      low_r[0][0] <= in_num_x[QW-1:0];
      low_r[0][1] <= in_num_y[QW-1:0];
      q_r[0][0]   <= '0;
      q_r[0][1]   <= '0;
      neg_r[0][0] <= in_neg_x;
      neg_r[0][1] <= in_neg_y;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[k]  <= div_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DVW:0] trial;
      logic         ge;
      always_comb begin
        trial = {rem_r[k-1][l], low_r[k-1][l][QW-1]};
        ge    = trial >= {1'b0, div_r[k-1]};
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k][l] <= ge ? DVW'(trial - {1'b0, div_r[k-1]}) : DVW'(trial);
          low_r[k][l] <= low_r[k-1][l] << 1;
          q_r[k][l]   <= {q_r[k-1][l][QW-2:0], ge};
          neg_r[k][l] <= neg_r[k-1][l];
        end
      end
    end
  end

  // floor of a negative dividend: complement in, complement out
  assign out_valid = v_r[QW];
  assign out_side  = side_r[QW];
  assign out_q_x   = {neg_r[QW][0], neg_r[QW][0] ? ~q_r[QW][0] : q_r[QW][0]};
  assign out_q_y   = {neg_r[QW][1], neg_r[QW][1] ? ~q_r[QW][1] : q_r[QW][1]};

endmodule

@@ rtl/segix_checker.sv @@
// ---------------------------------------------------------------------------
// segix_checker
// port-level checks of the segment intersection block, bound to the top
// ---------------------------------------------------------------------------
`include "segment_intersection_2d_macros.svh"

module segix_checker import segix_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input seg_pair_t in_word,
  input logic      out_valid,
  input logic      out_stall,
  input isect_t    out_word
);

  // a held result stays offered
  `SEGIX_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "out word dropped while stalled")

  // a blocked output blocks the input side
  `SEGIX_ASSERT_NOW(a_stall_back, clk, rst_n, out_valid && out_stall, in_stall, "input taken while output blocked")

  // a stalled input word stays offered and unchanged
  `SEGIX_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_word), "in word changed while stalled")

  // no hit means an all-zero result
  `SEGIX_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !out_word.hit, out_word.point_x == '0 && out_word.point_y == '0 && !out_word.collinear, "miss word not zero")

  // collinear flag only on a hit
  `SEGIX_ASSERT_NOW(a_col_hit, clk, rst_n, out_valid && out_word.collinear, out_word.hit, "collinear without hit")

endmodule

bind segment_intersection_2d segix_checker u_segix_checker (.*);
